FILE: src/lsc_pkg.sv
package lsc_pkg;

    localparam int COORD_BITS_DEF = 16;

    // window edges need at least this many bits to hold their reset values
    localparam int WIN_BITS_MIN = 9;

    localparam int RST_X_MIN = 0;
    localparam int RST_Y_MIN = 0;
    localparam int RST_X_MAX = 199;
    localparam int RST_Y_MAX = 149;

    localparam int MAX_STEPS = 8;
    localparam int STEP_BITS = 4;

    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_X_MIN = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_Y_MIN = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_X_MAX = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_Y_MAX = 2'd3;

    localparam logic [1:0] VERDICT_TRIVIAL = 2'd0;
    localparam logic [1:0] VERDICT_CLIPPED = 2'd1;
    localparam logic [1:0] VERDICT_REJECT  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_WAIT,
        S_OUT
    } t_seq_state;

    typedef enum logic [1:0] {
        CX_IDLE,
        CX_MUL,
        CX_DIV,
        CX_DONE
    } t_cross_state;

endpackage

FILE: src/lsc_cross.sv
// Edge crossing unit: base + trunc(d_other * offset / d_this).
// Loads the magnitudes, then multiplies, then runs WB restoring divide steps,
// then a done state with the result. Needs |offset| <= |d_this|, which the
// outcode logic guarantees, so the quotient fits in WB bits.
module lsc_cross #(
    parameter int WB = lsc_pkg::WIN_BITS_MIN
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [WB-1:0] i_base,
    input  logic signed [WB:0]   i_d_other,
    input  logic signed [WB:0]   i_offset,
    input  logic signed [WB:0]   i_d_this,
    output logic                 o_done,
    output logic signed [WB-1:0] o_result
);

    localparam int CW = $clog2(WB + 1);

    lsc_pkg::t_cross_state r_state, n_state;

    logic          r_neg, n_neg;
    logic [WB-1:0] r_a, n_a;
    logic [WB-1:0] r_b, n_b;
    logic [WB-1:0] r_c, n_c;
    logic [WB-1:0] r_base, n_base;
    logic [WB-1:0] r_rem, n_rem;
    logic [WB-1:0] r_quo, n_quo;
    logic [CW-1:0] r_cnt, n_cnt;

    logic [WB:0]     mag_other, mag_off, mag_this;
    logic [2*WB-1:0] prod;
    logic [WB:0]     rem_sh;
    logic            fits;
    logic [WB:0]     rem_sub;

    always_comb begin
        mag_other = i_d_other[WB] ? (~i_d_other + 1'b1) : i_d_other;
        mag_off   = i_offset[WB]  ? (~i_offset + 1'b1)  : i_offset;
        mag_this  = i_d_this[WB]  ? (~i_d_this + 1'b1)  : i_d_this;
        prod      = r_a * r_b;
        rem_sh    = {r_rem, r_quo[WB-1]};
        fits      = rem_sh >= {1'b0, r_c};
        rem_sub   = rem_sh - {1'b0, r_c};
    end

    always_comb begin
        n_state = r_state;
        n_neg   = r_neg;
        n_a     = r_a;
        n_b     = r_b;
        n_c     = r_c;
        n_base  = r_base;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        o_done  = 1'b0;
        case (r_state)
            lsc_pkg::CX_IDLE: begin
                if (i_start) begin
                    n_neg   = i_d_other[WB] ^ i_offset[WB] ^ i_d_this[WB];
                    n_a     = mag_other[WB-1:0];
                    n_b     = mag_off[WB-1:0];
                    n_c     = mag_this[WB-1:0];
                    n_base  = i_base;
                    n_state = lsc_pkg::CX_MUL;
                end
            end
            lsc_pkg::CX_MUL: begin
                // upper half is below the divisor since the quotient fits WB bits
                n_rem   = prod[2*WB-1:WB];
                n_quo   = prod[WB-1:0];
                n_cnt   = CW'(WB);
                n_state = lsc_pkg::CX_DIV;
            end
            lsc_pkg::CX_DIV: begin
                n_rem = fits ? rem_sub[WB-1:0] : rem_sh[WB-1:0];
                n_quo = {r_quo[WB-2:0], fits};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    n_state = lsc_pkg::CX_DONE;
                end
            end
            lsc_pkg::CX_DONE: begin
                o_done  = 1'b1;
                n_state = lsc_pkg::CX_IDLE;
            end
            default: begin
                n_state = lsc_pkg::CX_IDLE;
            end
        endcase
    end

    assign o_result = r_neg ? (r_base - r_quo) : (r_base + r_quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsc_pkg::CX_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_neg  <= n_neg;
        r_a    <= n_a;
        r_b    <= n_b;
        r_c    <= n_c;
        r_base <= n_base;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
    end

endmodule

FILE: src/line_segment_clipper.sv
// Channel   Dir  Payload
// s_axis    in   tdata: start_x, start_y, end_x, end_y (COORD_BITS each)
// m_axis    out  tdata: clip_start_x, clip_start_y, clip_end_x, clip_end_y;
//                tuser: verdict
// cfg       in   i_cfg_idx selects window_x_min, window_y_min, window_x_max,
//                window_y_max
//
// An item takes k clip steps (at most 8); WB = max(COORD_BITS, 9). Each step
// runs the shared multiply and restoring-divide unit. Reset (synchronous)
// restores the window to x 0..199, y 0..149. Input is taken only between
// items; a finished result waits in the output register while the next item
// is accepted.
module line_segment_clipper #(
    parameter int COORD_BITS = lsc_pkg::COORD_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // start_x, start_y, end_x, end_y from bit 0 up, zero padded
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // clip_start_x, clip_start_y, clip_end_x, clip_end_y from bit 0 up
    output logic [((4*COORD_BITS+7)/8)*8-1:0]     m_axis_tdata,
    // verdict
    output logic [1:0]                            m_axis_tuser,
    input  logic                                  i_cfg_we,
    input  logic [lsc_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  logic [COORD_BITS-1:0]                 i_cfg_data
);

    localparam int W    = COORD_BITS;
    localparam int WB   = (W < lsc_pkg::WIN_BITS_MIN) ? lsc_pkg::WIN_BITS_MIN : W;
    localparam int BITS = ((4*W+7)/8)*8;

    lsc_pkg::t_seq_state r_state, n_state;

    logic signed [WB-1:0] r_x_min, r_y_min, r_x_max, r_y_max;
    logic signed [WB-1:0] r_ax, n_ax, r_ay, n_ay, r_bx, n_bx, r_by, n_by;
    logic [1:0]           r_verdict, n_verdict;
    logic [lsc_pkg::STEP_BITS-1:0] r_steps, n_steps;
    logic                 r_first, n_first;
    logic                 r_fix_y, n_fix_y;
    logic signed [WB-1:0] r_fixed, n_fixed;

    logic                 r_out_valid, n_out_valid;
    logic [BITS-1:0]      r_out_data, n_out_data;
    logic [1:0]           r_out_verdict, n_out_verdict;

    logic signed [W-1:0]  in_sx, in_sy, in_ex, in_ey;
    logic signed [W-1:0]  cfg_val;
    logic [3:0]           ca, cb, code;
    logic signed [WB:0]   dx, dy;
    logic                 cx_start, cx_done;
    logic signed [WB-1:0] cx_base, cx_result;
    logic signed [WB:0]   cx_other, cx_off, cx_this;
    logic                 win_bad;

    assign in_sx   = s_axis_tdata[W-1:0];
    assign in_sy   = s_axis_tdata[2*W-1:W];
    assign in_ex   = s_axis_tdata[3*W-1:2*W];
    assign in_ey   = s_axis_tdata[4*W-1:3*W];
    assign cfg_val = i_cfg_data;

    // outcode bits: 0 above, 1 below, 2 right, 3 left
    always_comb begin
        ca = {r_ax < r_x_min, r_ax > r_x_max, r_ay < r_y_min, r_ay > r_y_max};
        cb = {r_bx < r_x_min, r_bx > r_x_max, r_by < r_y_min, r_by > r_y_max};
        dx = (WB+1)'(r_bx) - (WB+1)'(r_ax);
        dy = (WB+1)'(r_by) - (WB+1)'(r_ay);
        win_bad = (r_x_min > r_x_max) || (r_y_min > r_y_max);
        code = (ca != 4'd0) ? ca : cb;
    end

    // edge pick: top, bottom, right, left
    always_comb begin
        cx_base  = r_ax;
        cx_other = dx;
        cx_this  = dy;
        cx_off   = (WB+1)'(r_y_max) - (WB+1)'(r_ay);
        n_fixed  = r_y_max;
        n_fix_y  = 1'b1;
        if (code[0]) begin
            cx_off  = (WB+1)'(r_y_max) - (WB+1)'(r_ay);
            n_fixed = r_y_max;
        end else if (code[1]) begin
            cx_off  = (WB+1)'(r_y_min) - (WB+1)'(r_ay);
            n_fixed = r_y_min;
        end else begin
            cx_base  = r_ay;
            cx_other = dy;
            cx_this  = dx;
            n_fix_y  = 1'b0;
            if (code[2]) begin
                cx_off  = (WB+1)'(r_x_max) - (WB+1)'(r_ax);
                n_fixed = r_x_max;
            end else begin
                cx_off  = (WB+1)'(r_x_min) - (WB+1)'(r_ax);
                n_fixed = r_x_min;
            end
        end
    end

    always_comb begin
        n_state       = r_state;
        n_ax          = r_ax;
        n_ay          = r_ay;
        n_bx          = r_bx;
        n_by          = r_by;
        n_verdict     = r_verdict;
        n_steps       = r_steps;
        n_first       = r_first;
        n_out_valid   = r_out_valid;
        n_out_data    = r_out_data;
        n_out_verdict = r_out_verdict;
        cx_start      = 1'b0;
        s_axis_tready = 1'b0;
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            lsc_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_ax      = WB'(in_sx);
                    n_ay      = WB'(in_sy);
                    n_bx      = WB'(in_ex);
                    n_by      = WB'(in_ey);
                    n_verdict = lsc_pkg::VERDICT_TRIVIAL;
                    n_steps   = '0;
                    n_state   = lsc_pkg::S_EVAL;
                end
            end
            lsc_pkg::S_EVAL: begin
                if (win_bad) begin
                    n_verdict = lsc_pkg::VERDICT_REJECT;
                    n_state   = lsc_pkg::S_OUT;
                end else if ((ca | cb) == 4'd0) begin
                    n_state = lsc_pkg::S_OUT;
                end else if ((ca & cb) != 4'd0 ||
                             r_steps >= lsc_pkg::STEP_BITS'(lsc_pkg::MAX_STEPS)) begin
                    n_verdict = lsc_pkg::VERDICT_REJECT;
                    n_state   = lsc_pkg::S_OUT;
                end else begin
                    n_verdict = lsc_pkg::VERDICT_CLIPPED;
                    n_steps   = r_steps + 1'b1;
                    n_first   = (ca != 4'd0);
                    cx_start  = 1'b1;
                    n_state   = lsc_pkg::S_WAIT;
                end
            end
            lsc_pkg::S_WAIT: begin
                if (cx_done) begin
                    if (r_first) begin
                        n_ax = r_fix_y ? cx_result : r_fixed;
                        n_ay = r_fix_y ? r_fixed : cx_result;
                    end else begin
                        n_bx = r_fix_y ? cx_result : r_fixed;
                        n_by = r_fix_y ? r_fixed : cx_result;
                    end
                    n_state = lsc_pkg::S_EVAL;
                end
            end
            lsc_pkg::S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid   = 1'b1;
                    n_out_verdict = r_verdict;
                    if (r_verdict == lsc_pkg::VERDICT_REJECT) begin
                        n_out_data = '0;
                    end else begin
                        n_out_data = BITS'({r_by[W-1:0], r_bx[W-1:0],
                                            r_ay[W-1:0], r_ax[W-1:0]});
                    end
                    n_state = lsc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lsc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lsc_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_x_min     <= WB'(lsc_pkg::RST_X_MIN);
            r_y_min     <= WB'(lsc_pkg::RST_Y_MIN);
            r_x_max     <= WB'(lsc_pkg::RST_X_MAX);
            r_y_max     <= WB'(lsc_pkg::RST_Y_MAX);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lsc_pkg::CFG_X_MIN: r_x_min <= WB'(cfg_val);
                    lsc_pkg::CFG_Y_MIN: r_y_min <= WB'(cfg_val);
                    lsc_pkg::CFG_X_MAX: r_x_max <= WB'(cfg_val);
                    lsc_pkg::CFG_Y_MAX: r_y_max <= WB'(cfg_val);
                    default: ;
                endcase
            end
        end
        r_ax          <= n_ax;
        r_ay          <= n_ay;
        r_bx          <= n_bx;
        r_by          <= n_by;
        r_verdict     <= n_verdict;
        r_steps       <= n_steps;
        r_first       <= n_first;
        if (cx_start) begin
            r_fix_y <= n_fix_y;
            r_fixed <= n_fixed;
        end
        r_out_data    <= n_out_data;
        r_out_verdict <= n_out_verdict;
    end

    lsc_cross #(
        .WB(WB)
    ) u_cross (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (cx_start),
        .i_base    (cx_base),
        .i_d_other (cx_other),
        .i_offset  (cx_off),
        .i_d_this  (cx_this),
        .o_done    (cx_done),
        .o_result  (cx_result)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_verdict;

endmodule

FILE: src/lsc_checker.sv
module lsc_checker #(
    parameter int COORD_BITS = lsc_pkg::COORD_BITS_DEF
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [((4*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    input logic [1:0]                        m_axis_tuser
);

    // one item in flight: input side closes right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an item is in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == lsc_pkg::VERDICT_TRIVIAL ||
                           m_axis_tuser == lsc_pkg::VERDICT_CLIPPED ||
                           m_axis_tuser == lsc_pkg::VERDICT_REJECT))
        else $error("bad verdict code");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == lsc_pkg::VERDICT_REJECT) |->
            (m_axis_tdata == '0))
        else $error("rejected segment with nonzero endpoints");

endmodule

bind line_segment_clipper lsc_checker #(
    .COORD_BITS(COORD_BITS)
) u_lsc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: bench/tb_top.sv
module tb_top;

    localparam int CB = lsc_pkg::COORD_BITS_DEF;
    localparam int DW = ((4 * CB + 7) / 8) * 8;
    localparam longint CMIN = -(longint'(1) << (CB - 1));
    localparam longint CMAX = (longint'(1) << (CB - 1)) - 1;
    localparam int LIMIT = 1000000;
    localparam int HOLD_LEN = 600;
    localparam int TAIL_CYCLES = 200;
    localparam int IDLE_PCT = 11;

    // outcode bits
    localparam bit [3:0] OC_TOP    = 4'b0001;
    localparam bit [3:0] OC_BOTTOM = 4'b0010;
    localparam bit [3:0] OC_RIGHT  = 4'b0100;
    localparam bit [3:0] OC_LEFT   = 4'b1000;

    typedef logic signed [CB-1:0] t_coord;

    typedef struct packed {
        logic [1:0] verdict;
        t_coord     sx;
        t_coord     sy;
        t_coord     ex;
        t_coord     ey;
    } t_clip_result;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [DW-1:0]                    s_axis_tdata = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [DW-1:0]                    m_axis_tdata;
    logic [1:0]                       m_axis_tuser;
    logic                             i_cfg_we = 1'b0;
    logic [lsc_pkg::CFG_IDX_BITS-1:0] i_cfg_idx = '0;
    logic [CB-1:0]                    i_cfg_data = '0;

    line_segment_clipper #(.COORD_BITS(CB)) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    // shadow of the window registers
    t_coord win_x_min = t_coord'(lsc_pkg::RST_X_MIN);
    t_coord win_y_min = t_coord'(lsc_pkg::RST_Y_MIN);
    t_coord win_x_max = t_coord'(lsc_pkg::RST_X_MAX);
    t_coord win_y_max = t_coord'(lsc_pkg::RST_Y_MAX);

    t_clip_result expected_clips[$];
    int  err_cnt = 0;
    int  cycle_cnt = 0;
    bit  steady = 1'b0;
    int  hold_req_cnt = 0;
    int  hold_seen_cnt = 0;
    int  hold_left = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------- prediction ----------------

    function automatic bit [3:0] outcode(longint x, longint y);
        bit [3:0] c = '0;
        if (y > win_y_max) c |= OC_TOP;
        if (y < win_y_min) c |= OC_BOTTOM;
        if (x > win_x_max) c |= OC_RIGHT;
        if (x < win_x_min) c |= OC_LEFT;
        return c;
    endfunction

    // base + d_other * offset / d_this, quotient truncated toward zero
    function automatic longint edge_cross(longint base, longint d_other, longint offset,
                                          longint d_this);
        if (d_this == 0) return base;
        return base + (d_other * offset) / d_this;
    endfunction

    function automatic t_clip_result predict_clip(t_coord sx, t_coord sy, t_coord ex,
                                                  t_coord ey);
        longint ax, ay, bx, by, dx, dy, nx, ny;
        longint xmin, ymin, xmax, ymax;
        bit [3:0] ca, cb, c;
        bit first;
        int steps;
        logic [1:0] verdict;
        t_clip_result r;
        ax = sx; ay = sy; bx = ex; by = ey;
        xmin = win_x_min; ymin = win_y_min; xmax = win_x_max; ymax = win_y_max;
        verdict = lsc_pkg::VERDICT_TRIVIAL;
        steps = 0;
        if (xmin > xmax || ymin > ymax) begin
            verdict = lsc_pkg::VERDICT_REJECT;
        end else begin
            ca = outcode(ax, ay);
            cb = outcode(bx, by);
            while ((ca | cb) != 0) begin
                if ((ca & cb) != 0 || steps >= lsc_pkg::MAX_STEPS) begin
                    verdict = lsc_pkg::VERDICT_REJECT;
                    break;
                end
                verdict = lsc_pkg::VERDICT_CLIPPED;
                steps++;
                first = (ca != 0);
                c = first ? ca : cb;
                dx = bx - ax;
                dy = by - ay;
                if ((c & OC_TOP) != 0) begin
                    nx = edge_cross(ax, dx, ymax - ay, dy);
                    ny = ymax;
                end else if ((c & OC_BOTTOM) != 0) begin
                    nx = edge_cross(ax, dx, ymin - ay, dy);
                    ny = ymin;
                end else if ((c & OC_RIGHT) != 0) begin
                    ny = edge_cross(ay, dy, xmax - ax, dx);
                    nx = xmax;
                end else begin
                    ny = edge_cross(ay, dy, xmin - ax, dx);
                    nx = xmin;
                end
                if (first) begin
                    ax = nx; ay = ny; ca = outcode(ax, ay);
                end else begin
                    bx = nx; by = ny; cb = outcode(bx, by);
                end
            end
        end
        if (verdict == lsc_pkg::VERDICT_REJECT) begin
            ax = 0; ay = 0; bx = 0; by = 0;
        end
        r.verdict = verdict;
        r.sx = ax[CB-1:0];
        r.sy = ay[CB-1:0];
        r.ex = bx[CB-1:0];
        r.ey = by[CB-1:0];
        return r;
    endfunction

    // ---------------- checking ----------------

    task automatic check_field(string name, logic [CB-1:0] want, logic [CB-1:0] got);
        if (want !== got) begin
            err_cnt++;
            if (err_cnt <= 10)
                $display("mismatch %s: expected %0d actual %0d", name,
                         $signed(want), $signed(got));
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_clip_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_clips.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected result: verdict %0d data %h", m_axis_tuser,
                             m_axis_tdata);
            end else begin
                want = expected_clips.pop_front();
                check_field("verdict", CB'(want.verdict), CB'(m_axis_tuser));
                check_field("clip_start_x", want.sx, m_axis_tdata[0*CB +: CB]);
                check_field("clip_start_y", want.sy, m_axis_tdata[1*CB +: CB]);
                check_field("clip_end_x", want.ex, m_axis_tdata[2*CB +: CB]);
                check_field("clip_end_y", want.ey, m_axis_tdata[3*CB +: CB]);
            end
        end
    end

    // receiver: random stalls, long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req_cnt != hold_seen_cnt) begin
            hold_seen_cnt <= hold_req_cnt;
            hold_left <= HOLD_LEN;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (steady) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ---------------- stimulus helpers ----------------

    task automatic send_segment(t_coord sx, t_coord sy, t_coord ex, t_coord ey);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= DW'({ey, ex, sy, sx});
        do @(posedge i_clk); while (!s_axis_tready);
        expected_clips.push_back(predict_clip(sx, sy, ex, ey));
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_clips.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [lsc_pkg::CFG_IDX_BITS-1:0] idx, t_coord val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            lsc_pkg::CFG_X_MIN: win_x_min = val;
            lsc_pkg::CFG_Y_MIN: win_y_min = val;
            lsc_pkg::CFG_X_MAX: win_x_max = val;
            lsc_pkg::CFG_Y_MAX: win_y_max = val;
            default: ;
        endcase
    endtask

    task automatic set_window(t_coord xmin, t_coord ymin, t_coord xmax, t_coord ymax);
        wait_idle();
        cfg_write(lsc_pkg::CFG_X_MIN, xmin);
        cfg_write(lsc_pkg::CFG_Y_MIN, ymin);
        cfg_write(lsc_pkg::CFG_X_MAX, xmax);
        cfg_write(lsc_pkg::CFG_Y_MAX, ymax);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_coord clamp_coord(longint v);
        if (v < CMIN) return t_coord'(CMIN);
        if (v > CMAX) return t_coord'(CMAX);
        return t_coord'(v);
    endfunction

    // mostly around the window, some edges, extremes and full-range values
    function automatic t_coord rand_coord(longint lo, longint hi);
        longint span, a, b;
        span = hi - lo + 1;
        if (span < 16) span = 16;
        case ($urandom_range(9))
            0, 1: return t_coord'($urandom);
            2: begin
                case ($urandom_range(3))
                    0: return clamp_coord(lo);
                    1: return clamp_coord(hi);
                    2: return clamp_coord(lo - 1);
                    default: return clamp_coord(hi + 1);
                endcase
            end
            3: return $urandom_range(1) ? t_coord'(CMAX) : t_coord'(CMIN);
            default: begin
                a = lo - span;
                b = hi + span;
                return clamp_coord(a + longint'($urandom_range(int'(b - a))));
            end
        endcase
    endfunction

    task automatic send_random_segment();
        longint xl, xh, yl, yh;
        t_coord sx, sy, ex, ey;
        xl = (win_x_min < win_x_max) ? win_x_min : win_x_max;
        xh = (win_x_min < win_x_max) ? win_x_max : win_x_min;
        yl = (win_y_min < win_y_max) ? win_y_min : win_y_max;
        yh = (win_y_min < win_y_max) ? win_y_max : win_y_min;
        sx = rand_coord(xl, xh);
        sy = rand_coord(yl, yh);
        ex = rand_coord(xl, xh);
        ey = rand_coord(yl, yh);
        case ($urandom_range(9))
            0: ex = sx;                 // vertical
            1: ey = sy;                 // horizontal
            2: begin                    // single point
                ex = sx;
                ey = sy;
            end
            default: ;
        endcase
        send_segment(sx, sy, ex, ey);
    endtask

    // ---------------- tests ----------------

    task automatic test_directed();
        // reset window: x 0..199, y 0..149
        send_segment(10, 10, 100, 100);
        send_segment(50, 50, 50, 50);
        send_segment(300, 50, 300, 50);
        send_segment(10, 200, 150, 300);
        send_segment(100, -50, 100, 200);
        send_segment(-50, 70, 300, 70);
        send_segment(-100, -100, 300, 300);
        send_segment(t_coord'(CMIN), t_coord'(CMIN), t_coord'(CMAX), t_coord'(CMAX));
        send_segment(t_coord'(CMAX), t_coord'(CMIN), t_coord'(CMIN), t_coord'(CMAX));
        send_segment(100, 100, 500, 120);
        send_segment(-20, -30, 60, 40);
        send_segment(-50, 120, 50, 220);    // clipped once, then rejected
        send_segment(0, 0, 199, 149);
        send_segment(-1, 150, 200, -1);
        send_segment(t_coord'(CMAX), t_coord'(CMAX), t_coord'(CMAX), t_coord'(CMAX));
        // inverted windows reject everything
        set_window(50, 40, 10, 100);
        send_segment(20, 50, 30, 60);
        send_segment(t_coord'(CMIN), t_coord'(CMIN), t_coord'(CMAX), t_coord'(CMAX));
        set_window(0, 100, 199, 50);
        send_segment(10, 60, 20, 70);
        // whole coordinate space
        set_window(t_coord'(CMIN), t_coord'(CMIN), t_coord'(CMAX), t_coord'(CMAX));
        send_segment(t_coord'(CMAX), t_coord'(CMIN), t_coord'(CMIN), t_coord'(CMAX));
        send_segment(-1, 0, 1, -1);
        // single-point window
        set_window(7, -5, 7, -5);
        send_segment(0, -10, 14, 0);
        send_segment(7, -5, 7, -5);
    endtask

    task automatic test_random_windows();
        longint cx, cy, w, h;
        for (int ph = 0; ph < 8; ph++) begin
            cx = longint'(t_coord'($urandom));
            cy = longint'(t_coord'($urandom));
            case (ph)
                0: set_window(t_coord'(lsc_pkg::RST_X_MIN), t_coord'(lsc_pkg::RST_Y_MIN),
                              t_coord'(lsc_pkg::RST_X_MAX), t_coord'(lsc_pkg::RST_Y_MAX));
                1, 2: begin
                    w = $urandom_range(ph == 1 ? 300 : 20000);
                    h = $urandom_range(ph == 1 ? 300 : 20000);
                    set_window(clamp_coord(cx - w), clamp_coord(cy - h),
                               clamp_coord(cx + w), clamp_coord(cy + h));
                end
                3: set_window(t_coord'(CMIN), t_coord'(CMIN), t_coord'(CMAX),
                              t_coord'(CMAX));
                4: set_window(clamp_coord(cx), clamp_coord(cy - 100), clamp_coord(cx),
                              clamp_coord(cy + 100));
                5: set_window(t_coord'(CMAX - 767), t_coord'(CMAX - 767), t_coord'(CMAX),
                              t_coord'(CMAX));
                6: set_window(t_coord'(CMIN), t_coord'(CMIN), t_coord'(CMIN + 768),
                              t_coord'(CMIN + 768));
                default: begin
                    w = 1 + $urandom_range(500);
                    set_window(clamp_coord(cx + w), clamp_coord(cy - w),
                               clamp_coord(cx - w), clamp_coord(cy + w));
                end
            endcase
            repeat (100) send_random_segment();
        end
    endtask

    // receiver stalls for a long stretch while items keep coming
    task automatic test_backpressure();
        set_window(-1000, -800, 1500, 900);
        hold_req_cnt++;
        repeat (150) send_random_segment();
    endtask

    // sender pauses mid-stream until every result is back
    task automatic test_drain_pause();
        set_window(-300, 20, 40, 700);
        repeat (50) send_random_segment();
        wait_idle();
        repeat (50) send_random_segment();
    endtask

    task automatic test_no_gaps();
        set_window(0, 0, 639, 479);
        steady = 1'b1;
        repeat (150) send_random_segment();
        steady = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_windows();
        test_backpressure();
        test_drain_pause();
        test_no_gaps();
        s_axis_tvalid <= 1'b0;
        while (expected_clips.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_clips.size() != 0) err_cnt++;
        if (err_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: line_segment_clipper.f
src/lsc_pkg.sv
src/lsc_cross.sv
src/line_segment_clipper.sv
src/lsc_checker.sv
bench/tb_top.sv
